// ===== hdl/bpp_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Boris particle push.
package bpp_pkg;

  localparam int WORD_W         = 32;  // port width of every Q16.16 / Q2.30 field
  localparam int WORD_WIDTH_DEF = 32;  // default saturation width
  localparam int SQ_W           = 63;  // Q31.32 squared speed
  localparam int TS_W           = 31;  // time step width
  localparam int PROD_W         = 64;
  localparam int RND30_W        = PROD_W - 30;
  localparam int SAT_W          = 49;  // widest pre-saturation sum
  localparam int NSTAGE         = 8;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t vec_t [3];
  typedef logic [SQ_W-1:0] sq_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SAT_W-1:0] wide_t;

  typedef enum logic [2:0] {
    CFG_TIME_STEP = 3'd0,
    CFG_ROT_EN    = 3'd1,
    CFG_ROT_T_X   = 3'd2,
    CFG_ROT_T_Y   = 3'd3,
    CFG_ROT_T_Z   = 3'd4,
    CFG_ROT_S_X   = 3'd5,
    CFG_ROT_S_Y   = 3'd6,
    CFG_ROT_S_Z   = 3'd7
  } cfg_reg_t;

  // clamp to a signed ww-bit word, result held in a 32-bit word
  function automatic word_t sat_word(input wide_t x, input int unsigned ww);
    wide_t hi;
    wide_t lo;
    hi = (SAT_W'(1) <<< (ww - 1)) - SAT_W'(1);
    lo = -hi - SAT_W'(1);
    if (x > hi) return hi[WORD_W-1:0];
    if (x < lo) return lo[WORD_W-1:0];
    return x[WORD_W-1:0];
  endfunction

  // Q16.16 x Q2.30 -> Q16.16, ties toward +inf
  function automatic logic signed [RND30_W-1:0] rnd_q30(input prod_t p);
    prod_t t;
    t = p + (PROD_W'(1) <<< 29);
    return t[PROD_W-1:30];
  endfunction

  // Q32.32 -> Q16.16, ties toward +inf
  function automatic logic signed [PROD_W-17:0] rnd_q16(input prod_t p);
    prod_t t;
    t = p + (PROD_W'(1) <<< 15);
    return t[PROD_W-1:16];
  endfunction

  // sum of three squares, clamped to 2^63-1
  function automatic sq_t sq_sum(input sq_t a, input sq_t b, input sq_t c);
    logic [SQ_W:0] s;
    s = {1'b0, a} + {1'b0, b} + {1'b0, c};
    return s[SQ_W] ? {SQ_W{1'b1}} : s[SQ_W-1:0];
  endfunction

endpackage

// ===== hdl/bpp_in_if.sv =====
// Input channel: particle state and half-step kick.
interface bpp_in_if import bpp_pkg::*;;
  logic  valid;
  logic  ready;
  word_t pos_x;
  word_t pos_y;
  word_t pos_z;
  word_t vel_x;
  word_t vel_y;
  word_t vel_z;
  word_t kick_x;
  word_t kick_y;
  word_t kick_z;

  modport source(output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                 kick_x, kick_y, kick_z, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
               kick_x, kick_y, kick_z, output ready);
endinterface

// ===== hdl/bpp_out_if.sv =====
// Result channel: updated particle and squared speeds.
interface bpp_out_if import bpp_pkg::*;;
  logic  valid;
  logic  ready;
  word_t new_pos_x;
  word_t new_pos_y;
  word_t new_pos_z;
  word_t new_vel_x;
  word_t new_vel_y;
  word_t new_vel_z;
  sq_t   speed_sq_before;
  sq_t   speed_sq_after;

  modport source(output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                 new_vel_z, speed_sq_before, speed_sq_after, input ready);
  modport sink(input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
               new_vel_z, speed_sq_before, speed_sq_after, output ready);
endinterface

// ===== hdl/bpp_cross.sv =====
// Two-stage cross-product accumulate: sum = sat(base + a x r), Q2.30 rotation vector.
module bpp_cross import bpp_pkg::*; #(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic en_mul,
  input  logic en_add,
  input  vec_t base,
  input  vec_t a,
  input  vec_t r,
  output vec_t sum_r
);

  prod_t prod_r [6];
  vec_t  base_r;
  vec_t  sum_nxt;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      prod_r[0] <= a[1] * r[2];
      prod_r[1] <= a[2] * r[1];
      prod_r[2] <= a[2] * r[0];
      prod_r[3] <= a[0] * r[2];
      prod_r[4] <= a[0] * r[1];
      prod_r[5] <= a[1] * r[0];
      base_r    <= base;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_nxt[i] = sat_word(SAT_W'(base_r[i]) + SAT_W'(rnd_q30(prod_r[2*i]))
                            - SAT_W'(rnd_q30(prod_r[2*i+1])), WORD_WIDTH);
    end
  end

  always_ff @(posedge clk) begin
    if (en_add) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

// ===== hdl/boris_particle_push.sv =====
// Top level of the fixed-point Boris particle pusher.
// Eight-stage pipeline, one particle per clock while out_chan is not stalled. Stage 1
// applies the first kick and squares the input velocity, stages 2-3 and 4-5 are the two
// cross-product steps (a row of multipliers, then round, add and clamp), stage 6 applies
// the second kick, stage 7 multiplies by dt and squares the new velocity, stage 8 rounds,
// adds to the position and clamps. Each stage has its own valid bit and stalls only while
// the stage behind it is full, so bubbles close up under backpressure. Configuration
// writes take effect at once and must come while the pipeline is empty; with rotation
// disabled T and S are ignored.
module boris_particle_push import bpp_pkg::*; #(
  parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_idx,
  input  logic [WORD_W-1:0] cfg_data,
  bpp_in_if.sink           in_chan,
  bpp_out_if.source        out_chan
);

  // configuration
  logic [TS_W-1:0] time_step_r;
  logic            rot_en_r;
  vec_t            rot_t_r;
  vec_t            rot_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= TS_W'(65536);
      rot_en_r    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        rot_t_r[i] <= '0;
        rot_s_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        CFG_TIME_STEP: time_step_r <= cfg_data[TS_W-1:0];
        CFG_ROT_EN:    rot_en_r    <= cfg_data[0];
        CFG_ROT_T_X:   rot_t_r[0]  <= cfg_data;
        CFG_ROT_T_Y:   rot_t_r[1]  <= cfg_data;
        CFG_ROT_T_Z:   rot_t_r[2]  <= cfg_data;
        CFG_ROT_S_X:   rot_s_r[0]  <= cfg_data;
        CFG_ROT_S_Y:   rot_s_r[1]  <= cfg_data;
        CFG_ROT_S_Z:   rot_s_r[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NSTAGE:1] valid_r;
  logic [NSTAGE:1] en;

  always_comb begin
    en[NSTAGE] = !valid_r[NSTAGE] || out_chan.ready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en[1]) begin
        valid_r[1] <= in_chan.valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  assign in_chan.ready = en[1];

  // stage 1: first kick, input squares
  vec_t in_pos, in_vel, in_kick, vk_nxt;
  vec_t s1_pos_r, s1_kick_r, s1_vk_r;
  sq_t  s1_sq_r [3];

  assign in_pos  = '{in_chan.pos_x, in_chan.pos_y, in_chan.pos_z};
  assign in_vel  = '{in_chan.vel_x, in_chan.vel_y, in_chan.vel_z};
  assign in_kick = '{in_chan.kick_x, in_chan.kick_y, in_chan.kick_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vk_nxt[i] = sat_word(SAT_W'(in_vel[i]) + SAT_W'(in_kick[i]), WORD_WIDTH);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_pos_r  <= in_pos;
      s1_kick_r <= in_kick;
      s1_vk_r   <= vk_nxt;
      for (int i = 0; i < 3; i++) begin
        s1_sq_r[i] <= SQ_W'(prod_t'(in_vel[i]) * prod_t'(in_vel[i]));
      end
    end
  end

  // stages 2-3: u = v + v x T
  vec_t u_r;
  vec_t s2_pos_r, s2_kick_r, s2_vk_r;
  sq_t  s2_before_r;
  vec_t s3_pos_r, s3_kick_r, s3_vk_r;
  sq_t  s3_before_r;

  bpp_cross #(.WORD_WIDTH(WORD_WIDTH)) u_cross_t (
    .clk    (clk),
    .en_mul (en[2]),
    .en_add (en[3]),
    .base   (s1_vk_r),
    .a      (s1_vk_r),
    .r      (rot_t_r),
    .sum_r  (u_r)
  );

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_pos_r    <= s1_pos_r;
      s2_kick_r   <= s1_kick_r;
      s2_vk_r     <= s1_vk_r;
      s2_before_r <= sq_sum(s1_sq_r[0], s1_sq_r[1], s1_sq_r[2]);
    end
    if (en[3]) begin
      s3_pos_r    <= s2_pos_r;
      s3_kick_r   <= s2_kick_r;
      s3_vk_r     <= s2_vk_r;
      s3_before_r <= s2_before_r;
    end
  end

  // stages 4-5: v = v + u x S
  vec_t w_r;
  vec_t s4_pos_r, s4_kick_r, s4_vk_r;
  sq_t  s4_before_r;
  vec_t s5_pos_r, s5_kick_r, s5_vk_r;
  sq_t  s5_before_r;

  bpp_cross #(.WORD_WIDTH(WORD_WIDTH)) u_cross_s (
    .clk    (clk),
    .en_mul (en[4]),
    .en_add (en[5]),
    .base   (s3_vk_r),
    .a      (u_r),
    .r      (rot_s_r),
    .sum_r  (w_r)
  );

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_pos_r    <= s3_pos_r;
      s4_kick_r   <= s3_kick_r;
      s4_vk_r     <= s3_vk_r;
      s4_before_r <= s3_before_r;
    end
    if (en[5]) begin
      s5_pos_r    <= s4_pos_r;
      s5_kick_r   <= s4_kick_r;
      s5_vk_r     <= s4_vk_r;
      s5_before_r <= s4_before_r;
    end
  end

  // stage 6: second kick, rotation bypass when disabled
  vec_t v3_nxt;
  vec_t s6_pos_r, s6_vel_r;
  sq_t  s6_before_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v3_nxt[i] = sat_word(SAT_W'(rot_en_r ? w_r[i] : s5_vk_r[i]) + SAT_W'(s5_kick_r[i]),
                           WORD_WIDTH);
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_pos_r    <= s5_pos_r;
      s6_vel_r    <= v3_nxt;
      s6_before_r <= s5_before_r;
    end
  end

  // stage 7: v * dt and output squares
  word_t ts_s;
  prod_t s7_dp_r [3];
  sq_t   s7_sq_r [3];
  vec_t  s7_pos_r, s7_vel_r;
  sq_t   s7_before_r;

  assign ts_s = {1'b0, time_step_r};

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_pos_r    <= s6_pos_r;
      s7_vel_r    <= s6_vel_r;
      s7_before_r <= s6_before_r;
      for (int i = 0; i < 3; i++) begin
        s7_dp_r[i] <= s6_vel_r[i] * ts_s;
        s7_sq_r[i] <= SQ_W'(prod_t'(s6_vel_r[i]) * prod_t'(s6_vel_r[i]));
      end
    end
  end

  // stage 8: position advance, output register
  vec_t pos_nxt;
  vec_t s8_pos_r, s8_vel_r;
  sq_t  s8_before_r, s8_after_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_nxt[i] = sat_word(SAT_W'(s7_pos_r[i]) + SAT_W'(rnd_q16(s7_dp_r[i])), WORD_WIDTH);
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_pos_r    <= pos_nxt;
      s8_vel_r    <= s7_vel_r;
      s8_before_r <= s7_before_r;
      s8_after_r  <= sq_sum(s7_sq_r[0], s7_sq_r[1], s7_sq_r[2]);
    end
  end

  assign out_chan.valid           = valid_r[NSTAGE];
  assign out_chan.new_pos_x       = s8_pos_r[0];
  assign out_chan.new_pos_y       = s8_pos_r[1];
  assign out_chan.new_pos_z       = s8_pos_r[2];
  assign out_chan.new_vel_x       = s8_vel_r[0];
  assign out_chan.new_vel_y       = s8_vel_r[1];
  assign out_chan.new_vel_z       = s8_vel_r[2];
  assign out_chan.speed_sq_before = s8_before_r;
  assign out_chan.speed_sq_after  = s8_after_r;

  // input backpressure only when every stage holds a transaction and the sink stalls
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> ((&valid_r) && !out_chan.ready))
    else $error("input stalled with room in the pipeline");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (valid_r == '0))
    else $error("valid bits set after reset");

  // a delivered x velocity and z position fit the saturation width
  a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (sat_word(SAT_W'(out_chan.new_vel_x), WORD_WIDTH) == out_chan.new_vel_x
                        && sat_word(SAT_W'(out_chan.new_pos_z), WORD_WIDTH)
                           == out_chan.new_pos_z))
    else $error("result outside the saturation range");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the Boris particle pusher: random and directed particles vs. a predictor.
module testbench import bpp_pkg::*;;

  localparam int WW          = 32;
  localparam int PIPE_DEPTH  = 8;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [31:0] MAXW = 32'h7FFF_FFFF;
  localparam logic [31:0] MINW = 32'h8000_0000;
  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] HALF = 32'h2000_0000;  // 0.5 in Q2.30

  typedef struct packed {
    word_t [2:0] pos;
    word_t [2:0] vel;
    word_t [2:0] kick;
  } particle_t;

  typedef struct packed {
    word_t [2:0] pos;
    word_t [2:0] vel;
    sq_t         sq_before;
    sq_t         sq_after;
  } pushed_t;

  class push_scoreboard;
    longint  dt;
    bit      rot_on;
    longint  rot_t[3];
    longint  rot_s[3];
    pushed_t awaited[$];
    int      errors;

    function new();
      dt = 65536;
      rot_on = 0;
      errors = 0;
      for (int i = 0; i < 3; i++) begin
        rot_t[i] = 0;
        rot_s[i] = 0;
      end
    endfunction

    function void set_reg(cfg_reg_t idx, logic [31:0] data);
      case (idx)
        CFG_TIME_STEP: dt = longint'({33'd0, data[30:0]});
        CFG_ROT_EN:    rot_on = data[0];
        CFG_ROT_T_X:   rot_t[0] = longint'($signed(data));
        CFG_ROT_T_Y:   rot_t[1] = longint'($signed(data));
        CFG_ROT_T_Z:   rot_t[2] = longint'($signed(data));
        CFG_ROT_S_X:   rot_s[0] = longint'($signed(data));
        CFG_ROT_S_Y:   rot_s[1] = longint'($signed(data));
        CFG_ROT_S_Z:   rot_s[2] = longint'($signed(data));
        default: ;
      endcase
    endfunction

    function longint clamp_word(longint x);
      longint hi;
      hi = (longint'(1) <<< (WW - 1)) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
    endfunction

    // a*b - c*d, each Q16.16 x Q2.30 product rounded half up to Q16.16
    function longint cross_term(longint a, longint b, longint c, longint d);
      return ((a * b + (longint'(1) <<< 29)) >>> 30) - ((c * d + (longint'(1) <<< 29)) >>> 30);
    endfunction

    function sq_t speed_sq(longint a, longint b, longint c);
      logic [64:0] s;
      s = 65'(a * a) + 65'(b * b) + 65'(c * c);
      return (s > 65'h7FFF_FFFF_FFFF_FFFF) ? '1 : s[62:0];
    endfunction

    function pushed_t advance(particle_t p);
      pushed_t r;
      longint  v[3];
      longint  k[3];
      longint  u[3];
      longint  w[3];
      longint  step;
      for (int i = 0; i < 3; i++) begin
        v[i] = longint'($signed(p.vel[i]));
        k[i] = longint'($signed(p.kick[i]));
      end
      r.sq_before = speed_sq(v[0], v[1], v[2]);
      for (int i = 0; i < 3; i++) v[i] = clamp_word(v[i] + k[i]);
      if (rot_on) begin
        u[0] = clamp_word(v[0] + cross_term(v[1], rot_t[2], v[2], rot_t[1]));
        u[1] = clamp_word(v[1] + cross_term(v[2], rot_t[0], v[0], rot_t[2]));
        u[2] = clamp_word(v[2] + cross_term(v[0], rot_t[1], v[1], rot_t[0]));
        w[0] = clamp_word(v[0] + cross_term(u[1], rot_s[2], u[2], rot_s[1]));
        w[1] = clamp_word(v[1] + cross_term(u[2], rot_s[0], u[0], rot_s[2]));
        w[2] = clamp_word(v[2] + cross_term(u[0], rot_s[1], u[1], rot_s[0]));
        for (int i = 0; i < 3; i++) v[i] = w[i];
      end
      for (int i = 0; i < 3; i++) v[i] = clamp_word(v[i] + k[i]);
      r.sq_after = speed_sq(v[0], v[1], v[2]);
      for (int i = 0; i < 3; i++) begin
        step = (v[i] * dt + (longint'(1) <<< 15)) >>> 16;
        r.pos[i] = 32'(clamp_word(longint'($signed(p.pos[i])) + step));
        r.vel[i] = 32'(v[i]);
      end
      return r;
    endfunction

    function void note_particle(particle_t p);
      awaited.push_back(advance(p));
    endfunction

    function void compare_field(string what, longint want, longint seen);
      if (want != seen) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, seen);
      end
    endfunction

    function void check_result(pushed_t got);
      pushed_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: transaction with nothing expected, expected none got pos %h vel %h",
                 $time, got.pos, got.vel);
        return;
      end
      want = awaited.pop_front();
      for (int i = 0; i < 3; i++) begin
        compare_field($sformatf("new_pos[%0d]", i), longint'($signed(want.pos[i])),
                      longint'($signed(got.pos[i])));
        compare_field($sformatf("new_vel[%0d]", i), longint'($signed(want.vel[i])),
                      longint'($signed(got.vel[i])));
      end
      compare_field("speed_sq_before", longint'({1'b0, want.sq_before}),
                    longint'({1'b0, got.sq_before}));
      compare_field("speed_sq_after", longint'({1'b0, want.sq_after}),
                    longint'({1'b0, got.sq_after}));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [2:0]        cfg_idx;
  logic [WORD_W-1:0] cfg_data;
  bit                pacing;
  int unsigned       cycles = 0;
  push_scoreboard    board;

  bpp_in_if  in_if();
  bpp_out_if out_if();

  boris_particle_push #(.WORD_WIDTH(WW)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data),
    .in_chan(in_if.sink),
    .out_chan(out_if.source)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic particle_t particle_of(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                            logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                                            logic [31:0] kx, logic [31:0] ky, logic [31:0] kz);
    particle_t p;
    p.pos  = {pz, py, px};
    p.vel  = {vz, vy, vx};
    p.kick = {kz, ky, kx};
    return p;
  endfunction

  // mostly within +/-2^span, now and then a word extreme or a full random word
  function automatic logic [31:0] rnd_word(int unsigned span);
    logic signed [31:0] r;
    case ($urandom_range(0, 31))
      0: return MAXW;
      1: return MINW;
      2: return $urandom;
      default: begin
        r = $urandom_range(0, (32'd1 << (span + 1)) - 1);
        return r - (32'sd1 <<< span);
      end
    endcase
  endfunction

  function automatic particle_t random_particle();
    particle_t   p;
    int unsigned style;
    style = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      if (style == 0) begin
        p.pos[i]  = $urandom;
        p.vel[i]  = $urandom;
        p.kick[i] = $urandom;
      end else begin
        p.pos[i]  = rnd_word(26);
        p.vel[i]  = rnd_word(style < 3 ? 28 : 20);
        p.kick[i] = rnd_word(14);
      end
    end
    return p;
  endfunction

  task automatic program_reg(cfg_reg_t idx, logic [31:0] data);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    board.set_reg(idx, data);
  endtask

  task automatic load_rotation(logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                               logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
    program_reg(CFG_ROT_T_X, tx);
    program_reg(CFG_ROT_T_Y, ty);
    program_reg(CFG_ROT_T_Z, tz);
    program_reg(CFG_ROT_S_X, sx);
    program_reg(CFG_ROT_S_Y, sy);
    program_reg(CFG_ROT_S_Z, sz);
  endtask

  // T small enough to be a real gyro angle, S = 2T/(1+T.T)
  task automatic load_physical_rotation();
    real t[3];
    real s[3];
    real mag;
    for (int i = 0; i < 3; i++)
      t[i] = ($itor($urandom_range(0, 2000)) - 1000.0) / 1000.0 * 0.6;
    mag = 1.0 + t[0] * t[0] + t[1] * t[1] + t[2] * t[2];
    for (int i = 0; i < 3; i++) s[i] = 2.0 * t[i] / mag;
    load_rotation($rtoi(t[0] * 1073741824.0), $rtoi(t[1] * 1073741824.0),
                  $rtoi(t[2] * 1073741824.0), $rtoi(s[0] * 1073741824.0),
                  $rtoi(s[1] * 1073741824.0), $rtoi(s[2] * 1073741824.0));
  endtask

  // entered and left at a falling edge
  task automatic send_particle(particle_t p);
    int unsigned gap;
    gap = pacing ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.pos_x  = p.pos[0];
    in_if.pos_y  = p.pos[1];
    in_if.pos_z  = p.pos[2];
    in_if.vel_x  = p.vel[0];
    in_if.vel_y  = p.vel[1];
    in_if.vel_z  = p.vel[2];
    in_if.kick_x = p.kick[0];
    in_if.kick_y = p.kick[1];
    in_if.kick_z = p.kick[2];
    in_if.valid  = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    board.note_particle(p);
    @(negedge clk);
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (board.awaited.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 2) @(negedge clk);
  endtask

  task automatic run_phase(int count, logic [31:0] step, bit rot, bit wild_rot, bit paced);
    logic [31:0] en_word;
    drain();
    en_word = $urandom;
    en_word[0] = rot;
    program_reg(CFG_TIME_STEP, step);
    program_reg(CFG_ROT_EN, en_word);
    if (wild_rot)
      load_rotation($urandom, rnd_word(30), $urandom, rnd_word(30), $urandom, rnd_word(30));
    else
      load_physical_rotation();
    pacing = paced;
    repeat (count) send_particle(random_particle());
  endtask

  // result side
  initial begin
    int unsigned stall;
    pushed_t     got;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = pacing ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_if.ready = 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got.pos       = {out_if.new_pos_z, out_if.new_pos_y, out_if.new_pos_x};
      got.vel       = {out_if.new_vel_z, out_if.new_vel_y, out_if.new_vel_x};
      got.sq_before = out_if.speed_sq_before;
      got.sq_after  = out_if.speed_sq_after;
      board.check_result(got);
      @(negedge clk);
    end
  end

  initial begin
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_TIME_STEP;
    cfg_data = '0;
    pacing = 1'b1;
    in_if.valid = 1'b0;
    in_if.pos_x = '0;
    in_if.pos_y = '0;
    in_if.pos_z = '0;
    in_if.vel_x = '0;
    in_if.vel_y = '0;
    in_if.vel_z = '0;
    in_if.kick_x = '0;
    in_if.kick_y = '0;
    in_if.kick_z = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // defaults after reset: dt = 1.0, no rotation
    send_particle(particle_of(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_particle(particle_of(MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW));
    send_particle(particle_of(MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW, MINW));
    send_particle(particle_of(0, 0, 0, MINW, MINW, MINW, 0, 0, 0));
    send_particle(particle_of(MAXW, MINW, 0, 1, -1, 0, 0, 0, 0));
    send_particle(particle_of(ONE, -ONE, 0, MAXW, MINW, ONE, MINW, MAXW, -ONE));
    send_particle(particle_of(0, 0, 0, -1, 1, -1, -1, 1, 0));

    // dt = 0.5: position rounding ties on odd velocities
    drain();
    program_reg(CFG_TIME_STEP, 32'h0000_8000);
    send_particle(particle_of(0, 0, 0, 1, -1, 3, 0, 0, 0));
    send_particle(particle_of(5, -5, 0, -3, 3, 7, 0, 0, 0));

    // largest dt with extreme rotation vectors
    drain();
    program_reg(CFG_TIME_STEP, MAXW);
    program_reg(CFG_ROT_EN, 32'd1);
    load_rotation(MAXW, MINW, MAXW, MINW, MAXW, MINW);
    send_particle(particle_of(MAXW, MINW, 0, MAXW, MINW, MAXW, 0, 0, 0));
    send_particle(particle_of(0, 0, 0, MINW, MINW, MINW, MAXW, 0, MINW));
    send_particle(particle_of(0, 0, 0, ONE, ONE, ONE, 0, 0, 0));
    send_particle(particle_of(0, 0, 0, 0, 0, 0, 0, 0, 0));

    // dt = 0, T and S at +/-0.5 so odd velocities hit cross-product ties
    drain();
    program_reg(CFG_TIME_STEP, 32'd0);
    load_rotation(HALF, -HALF, HALF, HALF, HALF, -HALF);
    send_particle(particle_of(ONE, -ONE, 7, 1, -1, 3, 0, 0, 0));
    send_particle(particle_of(0, 0, 0, -3, 5, -7, 1, 1, -1));
    send_particle(particle_of(MAXW, MINW, MAXW, MAXW, MINW, MAXW, MAXW, MINW, MAXW));

    run_phase(100, ONE, 1'b1, 1'b0, 1'b1);
    run_phase(100, $urandom, 1'b1, 1'b1, 1'b1);
    run_phase(80, $urandom_range(0, 32'h0004_0000), 1'b0, 1'b0, 1'b0);
    run_phase(100, 32'h0000_0400, 1'b1, 1'b0, 1'b0);
    run_phase(100, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
    run_phase(120, $urandom_range(0, 32'h0004_0000), 1'b1, 1'b0, 1'b1);

    drain();
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bpp_pkg.sv
hdl/bpp_in_if.sv
hdl/bpp_out_if.sv
hdl/bpp_cross.sv
hdl/boris_particle_push.sv
bench/testbench.sv
